@@ src/bed_pkg.sv @@
// ----------------------------------------------------------------------------
// bed_pkg: shared types and constants of the backslash escape decoder
// Decode modes, the per-string state record and the result request bundle
// passed from the decode logic to the output queue.
// ----------------------------------------------------------------------------
package bed_pkg;

  // line size of the output; at most LINE_SIZE - 1 bytes leave per string
  localparam int LINE_SIZE = 4096;
  localparam int CNT_W     = $clog2(LINE_SIZE);
  localparam logic [CNT_W-1:0] EMIT_CAP    = CNT_W'(LINE_SIZE - 1);
  localparam logic [CNT_W-1:0] EMIT_CAP_M1 = CNT_W'(LINE_SIZE - 2);

  // output queue depth
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CODE_BEL  = 8'h07;
  localparam logic [7:0] CODE_BS   = 8'h08;
  localparam logic [7:0] CODE_ESC  = 8'h1B;
  localparam logic [7:0] CODE_FF   = 8'h0C;
  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_TAB  = 8'h09;
  localparam logic [7:0] CODE_VT   = 8'h0B;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_BSLASH = 3'd1,
    MODE_OCTAL  = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_STOP   = 3'd4
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [7:0]       value;
    logic [1:0]       dcount;
    logic [CNT_W-1:0] emitted;
  } dec_state_t;

  // up to two results of one request; v1 implies v0, the later one is last
  typedef struct packed {
    logic       v0;
    logic [7:0] b0;
    logic       v1;
    logic [7:0] b1;
  } push_t;

endpackage

@@ src/bed_decode.sv @@
// ----------------------------------------------------------------------------
// bed_decode: per-byte decode logic
// From the current string state and one input byte, computes the results
// (after the output cap) and the next string state. Purely combinational.
// ----------------------------------------------------------------------------
module bed_decode (
  input  bed_pkg::dec_state_t state_cur,
  input  logic                esc_en,
  input  logic [7:0]          in_byte,
  input  logic                eos,
  output bed_pkg::dec_state_t state_nxt,
  output bed_pkg::push_t      push
);
  import bed_pkg::*;

  logic       plain_esc;
  logic       oct_ok;
  logic [7:0] oct_val;
  logic       hex_ok;
  logic [3:0] hex_nib;
  logic [7:0] hex_val;

  mode_t      mode_mid;
  logic [7:0] value_mid;
  logic [1:0] dcount_mid;
  logic       p0_v, p1_v, f_v;
  logic [7:0] p0_b, p1_b, f_b;
  logic       a_v, b_v;
  logic [7:0] a_b, b_b;
  logic       acc_a, acc_b;

  assign plain_esc = esc_en && (in_byte == CH_BSLASH);
  assign oct_ok    = (in_byte[7:3] == CH_ZERO[7:3]);
  assign oct_val   = {state_cur.value[4:0], in_byte[2:0]};
  assign hex_val   = {state_cur.value[3:0], hex_nib};

  // hex digit classification
  always_comb begin
    hex_ok  = 1'b0;
    hex_nib = in_byte[3:0];
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_ok = 1'b1;
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_ok  = 1'b1;
      hex_nib = in_byte[3:0] + 4'd9;
    end
  end

  // main step
  always_comb begin
    mode_mid   = state_cur.mode;
    value_mid  = state_cur.value;
    dcount_mid = state_cur.dcount;
    p0_v       = 1'b0;
    p0_b       = in_byte;
    p1_v       = 1'b0;
    p1_b       = in_byte;
    unique case (state_cur.mode)
      MODE_BSLASH: begin
        mode_mid = MODE_NORMAL;
        p0_v     = 1'b1;
        unique case (in_byte)
          CH_BSLASH: p0_b = CH_BSLASH;
          CH_A:      p0_b = CODE_BEL;
          CH_B:      p0_b = CODE_BS;
          CH_E:      p0_b = CODE_ESC;
          CH_F:      p0_b = CODE_FF;
          CH_N:      p0_b = CODE_LF;
          CH_R:      p0_b = CODE_CR;
          CH_T:      p0_b = CODE_TAB;
          CH_V:      p0_b = CODE_VT;
          CH_C: begin
            p0_v     = 1'b0;
            mode_mid = MODE_STOP;
          end
          CH_ZERO: begin
            p0_v       = 1'b0;
            mode_mid   = MODE_OCTAL;
            value_mid  = '0;
            dcount_mid = '0;
          end
          CH_X: begin
            p0_v       = 1'b0;
            mode_mid   = MODE_HEX;
            value_mid  = '0;
            dcount_mid = '0;
          end
          default: begin
            p0_b = CH_BSLASH;
            p1_v = 1'b1;
          end
        endcase
      end
      MODE_OCTAL: begin
        if (oct_ok) begin
          value_mid  = oct_val;
          dcount_mid = state_cur.dcount + 2'd1;
          if (state_cur.dcount == 2'd2) begin
            p0_v     = 1'b1;
            p0_b     = oct_val;
            mode_mid = MODE_NORMAL;
          end
        end else begin
          p0_v     = 1'b1;
          p0_b     = state_cur.value;
          mode_mid = plain_esc ? MODE_BSLASH : MODE_NORMAL;
          p1_v     = !plain_esc;
        end
      end
      MODE_HEX: begin
        if (hex_ok) begin
          value_mid  = hex_val;
          dcount_mid = state_cur.dcount + 2'd1;
          if (state_cur.dcount == 2'd1) begin
            p0_v     = 1'b1;
            p0_b     = hex_val;
            mode_mid = MODE_NORMAL;
          end
        end else begin
          p0_v     = 1'b1;
          p0_b     = (state_cur.dcount != 2'd0) ? state_cur.value : CH_X;
          mode_mid = plain_esc ? MODE_BSLASH : MODE_NORMAL;
          p1_v     = !plain_esc;
        end
      end
      MODE_STOP: begin
        mode_mid = MODE_STOP;
      end
      default: begin
        mode_mid = plain_esc ? MODE_BSLASH : MODE_NORMAL;
        p0_v     = !plain_esc;
      end
    endcase
  end

  // end-of-string flush of a pending escape
  always_comb begin
    f_v = 1'b0;
    f_b = CH_BSLASH;
    if (eos) begin
      unique case (mode_mid)
        MODE_OCTAL: begin
          f_v = 1'b1;
          f_b = value_mid;
        end
        MODE_HEX: begin
          f_v = 1'b1;
          f_b = (dcount_mid != 2'd0) ? value_mid : CH_X;
        end
        MODE_BSLASH: f_v = 1'b1;
        default:     f_v = 1'b0;
      endcase
    end
  end

  // first two candidates in order, then the line cap
  always_comb begin
    if (p0_v) begin
      a_v = 1'b1;
      a_b = p0_b;
      b_v = p1_v ? 1'b1 : f_v;
      b_b = p1_v ? p1_b : f_b;
    end else begin
      a_v = f_v;
      a_b = f_b;
      b_v = 1'b0;
      b_b = f_b;
    end
  end

  assign acc_a = a_v && (state_cur.emitted < EMIT_CAP);
  assign acc_b = b_v && (state_cur.emitted < EMIT_CAP_M1);

  assign push.v0 = acc_a;
  assign push.b0 = a_b;
  assign push.v1 = acc_b;
  assign push.b1 = b_b;

  always_comb begin
    if (eos) begin
      state_nxt.mode    = MODE_NORMAL;
      state_nxt.value   = '0;
      state_nxt.dcount  = '0;
      state_nxt.emitted = '0;
    end else begin
      state_nxt.mode    = mode_mid;
      state_nxt.value   = value_mid;
      state_nxt.dcount  = dcount_mid;
      state_nxt.emitted = state_cur.emitted + CNT_W'(acc_a) + CNT_W'(acc_b);
    end
  end

endmodule

@@ src/bed_outq.sv @@
// ----------------------------------------------------------------------------
// bed_outq: result queue
// Small register queue taking up to two results per cycle and handing out
// one per cycle on the valid/stall output channel while out_stall is low.
// ----------------------------------------------------------------------------
module bed_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_en,
  input  bed_pkg::push_t push,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last
);
  import bed_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } entry_t;

  entry_t           mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0] count_r, count_nxt;
  logic [OQ_CW-1:0] push_n;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_byte  = mem_r[rd_ptr_r].data;
  assign out_last  = mem_r[rd_ptr_r].last;
  assign pop       = out_valid && !out_stall;
  // set when there is no room for two more results
  assign full      = (count_r > OQ_CW'(OQ_DEPTH - 2));

  assign push_n     = push_en ? (OQ_CW'(push.v0) + OQ_CW'(push.v1)) : '0;
  assign wr_ptr_nxt = wr_ptr_r + push_n[OQ_AW-1:0];
  assign rd_ptr_nxt = rd_ptr_r + OQ_AW'(pop);
  assign count_nxt  = count_r + push_n - OQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && push.v0) begin
      mem_r[wr_ptr_r] <= '{data: push.b0, last: !push.v1};
    end
    if (push_en && push.v1) begin
      mem_r[wr_ptr_r + OQ_AW'(1)] <= '{data: push.b1, last: 1'b1};
    end
  end

endmodule

@@ src/backslash_escape_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// backslash_escape_decoder_unit: echo-style backslash escape decoder
// Decodes a byte string with backslash escapes into output bytes, with an
// output cap per string and a run-time switch to pass bytes unchanged.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid, in_stall, in_byte,            | in
//           | in_end_of_string                        |
//  result   | out_valid, out_stall, out_byte, out_last| out
//  config   | cfg_wr_en, cfg_wr_data (escape enable)  | in
//
//  one input byte per cycle unless in_stall; each byte gives zero, one or
//  two result requests, written into a four-entry queue in the cycle it is
//  taken; results leave one per cycle unless out_stall, so the queue port
//  sets the long-run rate: bytes that give two results can make the input
//  stall; in_stall is high while the queue holds three or more results
//  synchronous active-low reset: normal mode, empty queue, escapes enabled
//
module backslash_escape_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import bed_pkg::*;

  // escape enable register
  logic       esc_en_r;

  // per-string decode state: mode, pending digits, bytes emitted so far
  dec_state_t state_r, state_nxt;

  // results of the byte on the input ports
  push_t      push;
  logic       q_full;
  logic       in_acc;

  // a byte is taken only when the queue can hold both of its results
  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      esc_en_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: MODE_NORMAL, value: '0, dcount: '0, emitted: '0};
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // combinational decode of one byte against the stored state
  bed_decode u_decode (
    .state_cur (state_r),
    .esc_en    (esc_en_r),
    .in_byte   (in_byte),
    .eos       (in_end_of_string),
    .state_nxt (state_nxt),
    .push      (push)
  );

  // result queue, doubles as the output register
  bed_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (in_acc),
    .push      (push),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // end of string brings the decoder back to a clean normal state
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_string) |=>
      (state_r.mode == MODE_NORMAL && state_r.emitted == '0))
    else $error("state not cleared after end of string");

  // the emitted count never passes the line cap
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.emitted <= EMIT_CAP)
    else $error("emitted count beyond cap");

  // after the stop escape nothing more is produced
  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && state_r.mode == MODE_STOP) |-> (!push.v0 && !push.v1))
    else $error("result produced after stop escape");

  // with escapes off, normal mode never starts an escape
  a_plain_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_end_of_string && state_r.mode == MODE_NORMAL && !esc_en_r)
      |=> (state_r.mode == MODE_NORMAL))
    else $error("escape started while escapes disabled");

endmodule

@@ sim/escape_decode_checker.sv @@
// ----------------------------------------------------------------------------
// escape_decode_checker: result checker of the backslash escape decoder
// Follows the escape enable writes and the accepted input requests, decodes
// each byte with its own copy of the decoder state, and compares every
// accepted result with the oldest decoded byte still waiting.
// ----------------------------------------------------------------------------
module escape_decode_checker
  import bed_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_string,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_byte,
  input  logic              out_last,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  output int unsigned       fail_count,
  output int unsigned       pending_count
);

  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_t;

  decoded_t expected_bytes[$];

  // decoder copy
  logic             esc_en;
  mode_t            dmode;
  logic [8:0]       dval;
  logic [1:0]       dcnt;
  logic [CNT_W-1:0] emitted;

  // results of the byte being decoded
  logic [7:0] step_bytes[2];
  int         step_n;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // output cap and at most two results per byte
  task automatic put_byte(input logic [8:0] v);
    if (emitted < EMIT_CAP && step_n < 2) begin
      step_bytes[step_n] = v[7:0];
      step_n++;
      emitted++;
    end
  endtask

  task automatic take_plain(input logic [7:0] b);
    if (esc_en && b == CH_BSLASH)
      dmode = MODE_BSLASH;
    else
      put_byte({1'b0, b});
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    int hv;
    step_n = 0;
    case (dmode)
      MODE_BSLASH: begin
        dmode = MODE_NORMAL;
        case (b)
          CH_BSLASH: put_byte(CH_BSLASH);
          CH_A:      put_byte(CODE_BEL);
          CH_B:      put_byte(CODE_BS);
          CH_E:      put_byte(CODE_ESC);
          CH_F:      put_byte(CODE_FF);
          CH_N:      put_byte(CODE_LF);
          CH_R:      put_byte(CODE_CR);
          CH_T:      put_byte(CODE_TAB);
          CH_V:      put_byte(CODE_VT);
          CH_C:      dmode = MODE_STOP;
          CH_ZERO: begin
            dmode = MODE_OCTAL;
            dval  = '0;
            dcnt  = '0;
          end
          CH_X: begin
            dmode = MODE_HEX;
            dval  = '0;
            dcnt  = '0;
          end
          default: begin
            put_byte(CH_BSLASH);
            put_byte(b);
          end
        endcase
      end
      MODE_OCTAL: begin
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          dval = (dval << 3) + (b - CH_ZERO);
          dcnt = dcnt + 2'd1;
          if (dcnt >= 2'd3) begin
            put_byte(dval);
            dmode = MODE_NORMAL;
          end
        end else begin
          put_byte(dval);
          dmode = MODE_NORMAL;
          take_plain(b);
        end
      end
      MODE_HEX: begin
        if (b >= CH_ZERO && b <= CH_NINE)
          hv = b - CH_ZERO;
        else if (b >= CH_A && b <= CH_F)
          hv = b - CH_A + 10;
        else if (b >= CH_UPPER_A && b <= CH_UPPER_F)
          hv = b - CH_UPPER_A + 10;
        else
          hv = -1;
        if (hv >= 0) begin
          dval = (dval << 4) + hv;
          dcnt = dcnt + 2'd1;
          if (dcnt >= 2'd2) begin
            put_byte(dval);
            dmode = MODE_NORMAL;
          end
        end else begin
          put_byte(dcnt != 2'd0 ? dval : {1'b0, CH_X});
          dmode = MODE_NORMAL;
          take_plain(b);
        end
      end
      MODE_STOP: ;
      default: begin
        dmode = MODE_NORMAL;
        take_plain(b);
      end
    endcase

    // last byte flushes whatever is pending and clears the string state
    if (eos) begin
      if (dmode == MODE_OCTAL)
        put_byte(dval);
      else if (dmode == MODE_HEX)
        put_byte(dcnt != 2'd0 ? dval : {1'b0, CH_X});
      else if (dmode == MODE_BSLASH)
        put_byte(CH_BSLASH);
      dmode   = MODE_NORMAL;
      dval    = '0;
      dcnt    = '0;
      emitted = '0;
    end

    for (int k = 0; k < step_n; k++)
      expected_bytes.push_back({step_bytes[k], k == step_n - 1});
  endtask

  always @(posedge clk) begin : watch
    decoded_t want;
    if (!rst_n) begin
      esc_en  = 1'b1;
      dmode   = MODE_NORMAL;
      dval    = '0;
      dcnt    = '0;
      emitted = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en)
        esc_en = cfg_wr_data;
      if (in_valid && !in_stall)
        decode_byte(in_byte, in_end_of_string);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: byte %02h last %0b", out_byte, out_last);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data || out_last !== want.last) begin
            if (fail_count < 10)
              $display("result mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       want.data, want.last, out_byte, out_last);
            fail_count++;
          end
        end
      end
    end
    pending_count <= expected_bytes.size();
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the backslash escape decoder unit
// Drives directed strings and random escape-rich strings under random idling
// on both channels, setting the escape enable between phases; the checker
// predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  import bed_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_ITEMS = 1320;
  // cycles the block may still be busy after the last expected result
  localparam int          SETTLE       = 8;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte          = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_wr_en        = 1'b0;
  logic       cfg_wr_data      = 1'b0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  int          n_sent      = 0;

  // no idling on either side while set
  bit calm = 1'b0;

  // bytes of the string being built
  logic [7:0] text_q[$];

  string esc_letters = "abefnrtv\\";
  string hex_chars   = "0123456789abcdefABCDEF";

  always #10 clk = ~clk;

  backslash_escape_decoder_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  escape_decode_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  // receiver stalls at random, independent of out_valid
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 37);
  end

  // hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one input request: random idle gap, then hold until taken
  // only one assignment to in_valid per falling edge
  task automatic send_request(input logic [7:0] b, input logic eos);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // a literal string, end_of_string on its last byte when close is set
  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      send_request(s[i], close && (i == s.len() - 1));
  endtask

  task automatic send_built(input bit close);
    for (int i = 0; i < text_q.size(); i++)
      send_request(text_q[i], close && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  // sender pause: wait for every expected result, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // only called right after drain, so the block is idle
  task automatic write_enable(input logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // well-formed string: plain bytes and escapes of every kind
  task automatic build_string();
    int n_tok;
    int n_dig;
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(9))
        0, 1: text_q.push_back(8'($urandom_range(255)));
        2, 3: begin
          text_q.push_back(CH_BSLASH);
          text_q.push_back(esc_letters[$urandom_range(8)]);
        end
        4: begin
          // octal, zero to three digits
          text_q.push_back(CH_BSLASH);
          text_q.push_back(CH_ZERO);
          n_dig = $urandom_range(3);
          for (int d = 0; d < n_dig; d++)
            text_q.push_back(CH_ZERO + 8'($urandom_range(7)));
        end
        5: begin
          // hex, zero to two digits of either case
          text_q.push_back(CH_BSLASH);
          text_q.push_back(CH_X);
          n_dig = $urandom_range(2);
          for (int d = 0; d < n_dig; d++)
            text_q.push_back(hex_chars[$urandom_range(21)]);
        end
        6: begin
          // unknown escape, any following byte
          text_q.push_back(CH_BSLASH);
          text_q.push_back(8'($urandom_range(255)));
        end
        7: begin
          // stop escape, kept rare so strings stay mostly live
          if ($urandom_range(3) == 0) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(CH_C);
          end else begin
            text_q.push_back(8'($urandom_range(32, 126)));
          end
        end
        default: text_q.push_back(8'($urandom_range(32, 126)));
      endcase
    end
  endtask

  initial begin : stimulus
    int n_noise;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, NUL passes through
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b1);
    // unknown escape, complete octal with truncation, complete hex,
    // trailing lone backslash
    send_text("\\q\\0777\\xAf\\", 1'b1);
    // bare 0 ended by a non-octal byte
    send_text("\\09", 1'b1);
    // bare x ended by a backslash that starts a new escape
    send_text("\\x\\n", 1'b1);
    // stop escape drops the rest
    send_text("\\cz", 1'b1);
    // enable dropped mid-escape: the started escape still completes
    send_text("\\", 1'b0);
    drain();
    write_enable(1'b0);
    send_text("t", 1'b1);
    // escapes off: everything passes
    send_text("\\n", 1'b1);
    drain();
    write_enable(1'b1);

    // random part
    begin : random_part
      int start;
      start = n_sent;
      while (n_sent < start + RANDOM_ITEMS) begin
        calm = (n_sent >= start + 300) && (n_sent < start + 600);
        // occasional pause and enable change, sometimes mid-string
        if ($urandom_range(99) < 8) begin
          drain();
          write_enable(1'($urandom_range(1)));
        end
        if ($urandom_range(99) < 85) begin
          build_string();
          // a few strings run on into the next one
          send_built($urandom_range(99) >= 5);
        end else begin
          // noise: any bytes, end_of_string anywhere
          n_noise = $urandom_range(1, 8);
          for (int i = 0; i < n_noise; i++)
            send_request(8'($urandom_range(255)), $urandom_range(99) < 20);
        end
      end
      calm = 1'b0;
      send_request(8'($urandom_range(255)), 1'b1);
    end

    drain();
    if (fail_count == 0 && pending_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
src/bed_pkg.sv
src/bed_decode.sv
src/bed_outq.sv
src/backslash_escape_decoder_unit.sv
sim/escape_decode_checker.sv
sim/tb_top.sv
